[hdl/keyboard_scancode_key_tracker_macros.svh]
// assertion macros for the keyboard scancode key tracker
// included by the top level; no other dependencies
`ifndef KEYBOARD_SCANCODE_KEY_TRACKER_MACROS_SVH
`define KEYBOARD_SCANCODE_KEY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define KST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kst assertion failed");
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kst assertion failed");
`else
`define KST_ASSERT_SAME(label, clk, rst, ante, cons)
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/kst_pkg.sv]
// shared constants, types and key class functions of the key tracker
// no dependencies
`timescale 1ns / 1ps
package kst_pkg;
   localparam int TABLE_DEPTH_DEF   = 16;
   localparam int RELEASE_DEPTH_DEF = 6;

   localparam logic [1:0] FUNC_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_CONSUME = 2'd2;
   localparam logic [1:0] FUNC_READ    = 2'd3;

   localparam logic [7:0] TYPE_RELEASE = 8'h02;

   localparam logic [1:0] POS_FIRST = 2'd0;
   localparam logic [1:0] POS_TYPE  = 2'd1;
   localparam logic [1:0] POS_CODE  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_TICK  = 6'b000100,
      ST_CONS  = 6'b001000,
      ST_LATCH = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   typedef struct packed {
      logic       shift;
      logic       load;
      logic [7:0] data;
   } cell_ctrl_type;

   function automatic logic is_modifier(input logic [7:0] c);
      return (c == 8'h04) || (c == 8'h05) || (c == 8'h12);
   endfunction

   function automatic logic is_latched(input logic [7:0] c);
      logic r;
      case (c)
         8'h00, 8'h01, 8'h03, 8'h10, 8'h11, 8'h20, 8'h21, 8'h22,
         8'h30, 8'h31, 8'h40: r = 1'b1;
         default:             r = 1'b0;
      endcase
      return r;
   endfunction
endpackage

[hdl/kst_cell.sv]
// one key cell of a shift chain: holds a code, shifts from its neighbor,
// loads, and passes the match chain on; depends on kst_pkg
`timescale 1ns / 1ps
module kst_cell (
   input  logic                   clock,
   input  kst_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             neighbor,
   input  logic [7:0]             code,
   input  logic                   active,
   input  logic                   found_in,
   output logic [7:0]             key,
   output logic                   found_out
);
   import kst_pkg::*;

   logic [7:0] key_ff, key_in;

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift) key_in = neighbor;
      if (ctrl.load) key_in = ctrl.data;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key       = key_ff;
   assign found_out = found_in | (active & (key_ff == code));
endmodule

[hdl/keyboard_scancode_key_tracker.sv]
// keyboard scancode key tracker: a request passes ST_EXEC, then ST_FIN into the
// result register; a tick first walks the queued releases, a consume the held
// entries and, when those are replayed, the latched keys, one entry per cycle along
// the cell chains; one request at a time
// synchronous active-high reset clears counts, frame assembly and handshake
// state; the cell chains keep no reset and only entries below the counts are read
`timescale 1ns / 1ps
`include "keyboard_scancode_key_tracker_macros.svh"
module keyboard_scancode_key_tracker #(
   parameter int TABLE_DEPTH   = kst_pkg::TABLE_DEPTH_DEF,
   parameter int RELEASE_DEPTH = kst_pkg::RELEASE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [4:0] req_sent_count,
   input  logic [3:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_key_code,
   output logic [4:0] rsp_keys_held,
   output logic       rsp_frame_done,
   output logic       rsp_release_missed,
   output logic       rsp_overflow
);
   import kst_pkg::*;

   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int RCW = $clog2(RELEASE_DEPTH + 1);
   localparam int RIW = (RELEASE_DEPTH > 1) ? $clog2(RELEASE_DEPTH) : 1;

   // control state
   state_type      state_ff, state_in;
   logic [1:0]     pos_ff, pos_in;
   logic [7:0]     type_ff, type_in;
   logic [CW-1:0]  hcount_ff, hcount_in;
   logic [RCW-1:0] rcount_ff, rcount_in;
   logic [CW-1:0]  lcount_ff, lcount_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // captured request and work registers
   logic [1:0]     func_ff, func_in;
   logic [7:0]     byte_ff, byte_in;
   logic [4:0]     sent_ff, sent_in;
   logic [3:0]     ridx_ff, ridx_in;
   logic [CW-1:0]  lim_ff, lim_in;
   logic [CW-1:0]  prev_ff, prev_in;
   logic [CW-1:0]  k_ff, k_in;
   logic           normal_ff, normal_in;
   logic [7:0]     res_key_ff, res_key_in;
   logic           done_ff, done_in;
   logic           missed_ff, missed_in;
   logic           ovf_ff, ovf_in;

   // result register
   logic [7:0]     rsp_key_ff, rsp_key_in;
   logic [4:0]     rsp_held_ff, rsp_held_in;
   logic           rsp_done_ff, rsp_done_in;
   logic           rsp_missed_ff, rsp_missed_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   // chain controls
   logic           t_shift_all, t_shift_found, t_load;
   logic [IW-1:0]  t_widx;
   logic [7:0]     t_wdata, t_code;
   logic           q_shift, q_load;
   logic [RIW-1:0] q_widx;
   logic           l_shift, l_load;
   logic [IW-1:0]  l_widx;

   logic [7:0]     tkey [TABLE_DEPTH];
   logic           tfound [TABLE_DEPTH+1];
   logic [7:0]     qkey [RELEASE_DEPTH];
   logic           qfound [RELEASE_DEPTH+1];
   logic [7:0]     lkey [TABLE_DEPTH];
   logic           lfound [TABLE_DEPTH+1];

   logic           any_match;
   logic [7:0]     head;
   logic           in_sent;
   logic           out_free;

   assign tfound[0] = 1'b0;
   assign qfound[0] = 1'b0;
   assign lfound[0] = 1'b0;
   assign any_match = tfound[TABLE_DEPTH];
   assign head      = tkey[0];
   assign in_sent   = (k_ff < lim_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // held-key table: match chain runs from the front, a removal shifts
   // every cell at and behind the matching one
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_table
      cell_ctrl_type ctrl;
      logic [7:0]    nb;
      assign nb         = (i < TABLE_DEPTH - 1) ? tkey[(i + 1) % TABLE_DEPTH] : 8'h00;
      assign ctrl.shift = t_shift_all | (t_shift_found & tfound[i+1]);
      assign ctrl.load  = t_load && (t_widx == IW'(i));
      assign ctrl.data  = t_wdata;
      kst_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .neighbor  (nb),
         .code      (t_code),
         .active    (CW'(i) < hcount_ff),
         .found_in  (tfound[i]),
         .key       (tkey[i]),
         .found_out (tfound[i+1])
      );
   end

   // release queue: pushed at the tail, drained from the front on a tick
   for (genvar i = 0; i < RELEASE_DEPTH; i++) begin : g_queue
      cell_ctrl_type ctrl;
      logic [7:0]    nb;
      assign nb         = (i < RELEASE_DEPTH - 1) ? qkey[(i + 1) % RELEASE_DEPTH] : 8'h00;
      assign ctrl.shift = q_shift;
      assign ctrl.load  = q_load && (q_widx == RIW'(i));
      assign ctrl.data  = byte_ff;
      kst_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .neighbor  (nb),
         .code      (8'h00),
         .active    (1'b0),
         .found_in  (qfound[i]),
         .key       (qkey[i]),
         .found_out (qfound[i+1])
      );
   end

   // latched keys set aside during a consume, replayed in order
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_latch
      cell_ctrl_type ctrl;
      logic [7:0]    nb;
      assign nb         = (i < TABLE_DEPTH - 1) ? lkey[(i + 1) % TABLE_DEPTH] : 8'h00;
      assign ctrl.shift = l_shift;
      assign ctrl.load  = l_load && (l_widx == IW'(i));
      assign ctrl.data  = head;
      kst_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .neighbor  (nb),
         .code      (8'h00),
         .active    (1'b0),
         .found_in  (lfound[i]),
         .key       (lkey[i]),
         .found_out (lfound[i+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      type_in       = type_ff;
      hcount_in     = hcount_ff;
      rcount_in     = rcount_ff;
      lcount_in     = lcount_ff;
      rsp_valid_in  = rsp_valid_ff;
      func_in       = func_ff;
      byte_in       = byte_ff;
      sent_in       = sent_ff;
      ridx_in       = ridx_ff;
      lim_in        = lim_ff;
      prev_in       = prev_ff;
      k_in          = k_ff;
      normal_in     = normal_ff;
      res_key_in    = res_key_ff;
      done_in       = done_ff;
      missed_in     = missed_ff;
      ovf_in        = ovf_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_missed_in = rsp_missed_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      t_shift_all   = 1'b0;
      t_shift_found = 1'b0;
      t_load        = 1'b0;
      t_widx        = IW'(hcount_ff);
      t_wdata       = byte_ff;
      t_code        = byte_ff;
      q_shift       = 1'b0;
      q_load        = 1'b0;
      q_widx        = RIW'(rcount_ff);
      l_shift       = 1'b0;
      l_load        = 1'b0;
      l_widx        = IW'(lcount_ff);

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               byte_in  = req_rx_byte;
               sent_in  = req_sent_count;
               ridx_in  = req_read_index;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_key_in = 8'h00;
            done_in    = 1'b0;
            missed_in  = 1'b0;
            ovf_in     = 1'b0;
            state_in   = ST_FIN;
            unique case (func_ff)
               FUNC_BYTE: begin
                  case (pos_ff)
                     POS_FIRST: pos_in = POS_TYPE;
                     POS_TYPE: begin
                        type_in = byte_ff;
                        pos_in  = POS_CODE;
                     end
                     default: begin
                        pos_in  = POS_FIRST;
                        done_in = 1'b1;
                        if (type_ff == TYPE_RELEASE) begin
                           if (32'(rcount_ff) < RELEASE_DEPTH) begin
                              q_load    = 1'b1;
                              rcount_in = RCW'(rcount_ff + 1'b1);
                           end else begin
                              ovf_in = 1'b1;
                           end
                        end else if (!any_match) begin
                           // new key appended unless the table is full
                           if (32'(hcount_ff) < TABLE_DEPTH) begin
                              t_load    = 1'b1;
                              hcount_in = CW'(hcount_ff + 1'b1);
                           end else begin
                              ovf_in = 1'b1;
                           end
                        end
                     end
                  endcase
               end
               FUNC_TICK: state_in = ST_TICK;
               FUNC_CONSUME: begin
                  // sent count clamped to the held count
                  if (32'(sent_ff) > 32'(hcount_ff)) lim_in = hcount_ff;
                  else lim_in = CW'(sent_ff);
                  prev_in   = hcount_ff;
                  k_in      = '0;
                  lcount_in = '0;
                  normal_in = 1'b0;
                  state_in  = ST_CONS;
               end
               default: begin
                  if ((32'(ridx_ff) < 32'(hcount_ff)) && (32'(ridx_ff) < TABLE_DEPTH))
                     res_key_in = tkey[IW'(ridx_ff)];
               end
            endcase
         end
         ST_TICK: begin
            // one queued release per cycle: remove from the table, pop the queue
            if (rcount_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               t_code        = qkey[0];
               t_shift_found = 1'b1;
               q_shift       = 1'b1;
               rcount_in     = RCW'(rcount_ff - 1'b1);
               if (any_match) hcount_in = CW'(hcount_ff - 1'b1);
               else missed_in = 1'b1;
            end
         end
         ST_CONS: begin
            if (k_ff == prev_ff) begin
               if ((lcount_ff != '0) && !normal_ff) state_in = ST_LATCH;
               else state_in = ST_FIN;
            end else begin
               // pop the front entry, push it back at the tail when it stays
               t_shift_all = 1'b1;
               t_wdata     = head;
               t_widx      = IW'(hcount_ff - 1'b1);
               k_in        = CW'(k_ff + 1'b1);
               if (!in_sent || is_modifier(head)) begin
                  t_load = 1'b1;
               end else begin
                  hcount_in = CW'(hcount_ff - 1'b1);
                  if (is_latched(head)) begin
                     l_load    = 1'b1;
                     lcount_in = CW'(lcount_ff + 1'b1);
                  end else begin
                     normal_in = 1'b1;
                  end
               end
            end
         end
         ST_LATCH: begin
            // replay latched keys behind the kept entries
            if (lcount_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               l_shift   = 1'b1;
               t_load    = 1'b1;
               t_wdata   = lkey[0];
               hcount_in = CW'(hcount_ff + 1'b1);
               lcount_in = CW'(lcount_ff - 1'b1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_key_in    = res_key_ff;
               rsp_held_in   = 5'(hcount_ff);
               rsp_done_in   = done_ff;
               rsp_missed_in = missed_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_FIRST;
         type_ff      <= 8'h00;
         hcount_ff    <= '0;
         rcount_ff    <= '0;
         lcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         type_ff      <= type_in;
         hcount_ff    <= hcount_in;
         rcount_ff    <= rcount_in;
         lcount_ff    <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      byte_ff       <= byte_in;
      sent_ff       <= sent_in;
      ridx_ff       <= ridx_in;
      lim_ff        <= lim_in;
      prev_ff       <= prev_in;
      k_ff          <= k_in;
      normal_ff     <= normal_in;
      res_key_ff    <= res_key_in;
      done_ff       <= done_in;
      missed_ff     <= missed_in;
      ovf_ff        <= ovf_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_missed_ff <= rsp_missed_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_code       = rsp_key_ff;
   assign rsp_keys_held      = rsp_held_ff;
   assign rsp_frame_done     = rsp_done_ff;
   assign rsp_release_missed = rsp_missed_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // held and release counts stay within their chains
   `KST_ASSERT_SAME(a_hcount_range, clock, reset, 1'b1, 32'(hcount_ff) <= TABLE_DEPTH)
   `KST_ASSERT_SAME(a_rcount_range, clock, reset, 1'b1, 32'(rcount_ff) <= RELEASE_DEPTH)
   // an accepted request is dispatched next cycle
   `KST_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   // a finished request lands in the result register
   `KST_ASSERT_NEXT(a_fin_result, clock, reset, (state_ff == ST_FIN) && out_free, rsp_valid_ff)
endmodule

[tb/sv/keyboard_scancode_key_tracker_checker.sv]
// checker for the keyboard scancode key tracker: watches both channels,
// predicts every response and counts mismatches; depends on kst_pkg
`timescale 1ns / 1ps
module keyboard_scancode_key_tracker_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [4:0] req_sent_count,
   input  logic [3:0] req_read_index,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_key_code,
   input  logic [4:0] rsp_keys_held,
   input  logic       rsp_frame_done,
   input  logic       rsp_release_missed,
   input  logic       rsp_overflow,
   output int         fail_count,
   output int         pending,
   output int         rsp_seen
);
   import kst_pkg::*;

   localparam int TD = TABLE_DEPTH_DEF;
   localparam int RD = RELEASE_DEPTH_DEF;

   typedef struct packed {
      logic [7:0] key_code;
      logic [4:0] keys_held;
      logic       frame_done;
      logic       release_missed;
      logic       overflow;
   } tracker_rsp_type;

   tracker_rsp_type rsp_expected_q[$];
   logic [1:0] frame_pos;
   logic [7:0] frame_type;
   logic [7:0] keys[TD];
   int         key_cnt;
   logic [7:0] rel_q[RD];
   int         rel_cnt;

   function automatic bit key_present(logic [7:0] c);
      for (int i = 0; i < key_cnt; i++)
         if (keys[i] == c) return 1;
      return 0;
   endfunction

   // returns 1 when dropped for lack of room
   function automatic bit key_add(logic [7:0] c);
      if (key_present(c)) return 0;
      if (key_cnt >= TD) return 1;
      keys[key_cnt] = c;
      key_cnt++;
      return 0;
   endfunction

   // returns 1 when the key was not held
   function automatic bit key_remove(logic [7:0] c);
      for (int i = 0; i < key_cnt; i++)
         if (keys[i] == c) begin
            for (int k = i; k + 1 < key_cnt; k++) keys[k] = keys[k + 1];
            key_cnt--;
            return 0;
         end
      return 1;
   endfunction

   function automatic tracker_rsp_type predict_key_state(logic [1:0] f, logic [7:0] b,
                                                         logic [4:0] s, logic [3:0] ri);
      tracker_rsp_type r;
      logic [7:0] latch[TD];
      int nl, nn, fill, prev, sc, k;
      r = '0;
      nl = 0; nn = 0; fill = 0;
      case (f)
         FUNC_BYTE: begin
            if (frame_pos == POS_FIRST) frame_pos = POS_TYPE;
            else if (frame_pos == POS_TYPE) begin
               frame_type = b;
               frame_pos = POS_CODE;
            end else begin
               frame_pos = POS_FIRST;
               r.frame_done = 1;
               if (frame_type == TYPE_RELEASE) begin
                  if (rel_cnt < RD) begin
                     rel_q[rel_cnt] = b;
                     rel_cnt++;
                  end else r.overflow = 1;
               end else if (key_add(b)) r.overflow = 1;
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < rel_cnt; i++)
               if (key_remove(rel_q[i])) r.release_missed = 1;
            rel_cnt = 0;
         end
         FUNC_CONSUME: begin
            prev = key_cnt;
            sc = (s > prev) ? prev : s;
            for (k = 0; k < sc; k++) begin
               if (is_modifier(keys[k])) begin
                  keys[fill] = keys[k];
                  fill++;
               end else if (is_latched(keys[k])) begin
                  latch[nl] = keys[k];
                  nl++;
               end else nn++;
            end
            key_cnt = fill;
            for (; k < prev; k++)
               if (key_add(keys[k])) r.overflow = 1;
            if (nl > 0 && nn == 0)
               for (int i = 0; i < nl; i++)
                  if (key_add(latch[i])) r.overflow = 1;
         end
         default: if (ri < key_cnt) r.key_code = keys[ri];
      endcase
      r.keys_held = key_cnt[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      tracker_rsp_type got, want;
      if (reset) begin
         frame_pos = POS_FIRST;
         frame_type = '0;
         key_cnt = 0;
         rel_cnt = 0;
         rsp_expected_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (req_valid && req_ready)
            rsp_expected_q.push_back(predict_key_state(req_func, req_rx_byte,
                                                       req_sent_count, req_read_index));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_key_code, rsp_keys_held, rsp_frame_done, rsp_release_missed,
                   rsp_overflow};
            rsp_seen <= rsp_seen + 1;
            if (rsp_expected_q.size() == 0) begin
               $display("%0t: response with nothing expected, got %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_expected_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch key=%h/%h held=%0d/%0d done=%b/%b miss=%b/%b ovf=%b/%b",
                           $time, want.key_code, got.key_code, want.keys_held,
                           got.keys_held, want.frame_done, got.frame_done,
                           want.release_missed, got.release_missed,
                           want.overflow, got.overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= rsp_expected_q.size();
   end
endmodule

[tb/sv/keyboard_scancode_key_tracker_tb.sv]
// top of the key tracker testbench: clock, reset, request stimulus and verdict
// depends on kst_pkg, keyboard_scancode_key_tracker and its checker
`timescale 1ns / 1ps
module keyboard_scancode_key_tracker_tb;
   import kst_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_BYTE;
   logic [7:0] req_rx_byte = 0;
   logic [4:0] req_sent_count = 0;
   logic [3:0] req_read_index = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_key_code;
   logic [4:0] rsp_keys_held;
   logic       rsp_frame_done;
   logic       rsp_release_missed;
   logic       rsp_overflow;
   int         fail_count, pending, rsp_seen;

   // idling phase: 0 none, 1 sender idle, 2 receiver stalls, 3 both
   int         idle_phase = 0;
   bit         hold_off = 0;
   int         req_sent = 0;
   int         idle_cycles = 0;

   // handy key codes: modifiers, latched and normal
   localparam logic [7:0] KEY_POOL[12] = '{8'h04, 8'h05, 8'h12, 8'h00, 8'h01, 8'h22,
                                          8'h40, 8'h31, 8'h1c, 8'h3a, 8'h77, 8'hff};

   keyboard_scancode_key_tracker uut (.*);

   keyboard_scancode_key_tracker_checker chk (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall in its phases, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off) rsp_ready <= 0;
      else if (idle_phase == 2) rsp_ready <= ($urandom_range(99) >= 61);
      else if (idle_phase == 3) rsp_ready <= ($urandom_range(99) >= 15);
      else rsp_ready <= 1;
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("keyboard_scancode_key_tracker verification failed");
            $finish;
         end
      end
   end

   // one request; sender gap first in idle phases, valid stays up back to back
   task automatic send_req(logic [1:0] f, logic [7:0] b, logic [4:0] s, logic [3:0] ri);
      int gap_pct;
      gap_pct = (idle_phase == 1) ? 61 : (idle_phase == 3) ? 15 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_rx_byte <= b;
      req_sent_count <= s;
      req_read_index <= ri;
      do @(posedge clock); while (!req_ready);
      req_sent++;
   endtask

   task automatic send_frame(logic [7:0] kind, logic [7:0] code);
      send_req(FUNC_BYTE, 8'($urandom), 5'($urandom), 4'($urandom));
      send_req(FUNC_BYTE, kind, 5'($urandom), 4'($urandom));
      send_req(FUNC_BYTE, code, 5'($urandom), 4'($urandom));
   endtask

   function automatic logic [7:0] pick_key();
      return ($urandom_range(3) == 0) ? 8'($urandom) : KEY_POOL[$urandom_range(11)];
   endfunction

   initial begin
      int r;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: press, repeat, unknown, read, consume, release paths
      send_frame(8'h00, 8'h04);
      send_frame(8'h01, 8'h22);
      send_frame(8'hff, 8'h1c);
      send_frame(8'h00, 8'h1c);             // already held
      send_req(FUNC_READ, 8'h00, 5'd0, 4'd0);
      send_req(FUNC_READ, 8'h00, 5'd0, 4'd15); // index past the count
      send_req(FUNC_CONSUME, 8'h00, 5'd31, 4'd0); // sent above count
      send_frame(8'h02, 8'h04);
      send_frame(8'h02, 8'h99);             // release of a key not held
      send_req(FUNC_TICK, 8'h00, 5'd0, 4'd0);
      // consume during a partial frame
      send_req(FUNC_BYTE, 8'hff, 5'd0, 4'd0);
      send_req(FUNC_CONSUME, 8'h00, 5'd0, 4'd0);
      send_req(FUNC_BYTE, 8'h00, 5'd0, 4'd0);
      send_req(FUNC_BYTE, 8'h00, 5'd0, 4'd0);

      // random: mostly well-formed frames, phases cycle through idling modes
      for (int p = 0; p < 5; p++) begin
         idle_phase = p % 4;
         for (int n = 0; n < 190; n++) begin
            r = $urandom_range(99);
            if (r < 45) send_frame(($urandom_range(2) == 0) ? TYPE_RELEASE
                                   : 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(1)),
                                   pick_key());
            else if (r < 55) send_req(FUNC_BYTE, 8'($urandom), 5'($urandom), 4'($urandom));
            else if (r < 70) send_req(FUNC_TICK, 8'($urandom), 5'($urandom), 4'($urandom));
            else if (r < 82) send_req(FUNC_CONSUME, 8'($urandom), 5'($urandom_range(17)),
                                      4'($urandom));
            else send_req(FUNC_READ, 8'($urandom), 5'($urandom), 4'($urandom));
            if (p == 2 && n == 60) begin
               // long receiver hold-off while requests keep coming
               hold_off = 1;
               fork
                  begin repeat (300) @(posedge clock); hold_off = 0; end
               join_none
            end
         end
      end
      req_valid <= 0;

      // all requests are in; drain
      while (pending != 0 || hold_off) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("run sent %0d requests and checked %0d responses", req_sent, rsp_seen);
      $display("covered frames, ticks, consumes, reads and overflow across idling phases");
      if (fail_count == 0) $display("keyboard_scancode_key_tracker verification clean");
      else $display("keyboard_scancode_key_tracker verification failed");
      $finish;
   end
endmodule
